### rtl/assert_macros.svh
// Assertion macros shared by the finite-difference extrapolator RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define FDE_ASSERT(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: assertion failed");

// Antecedent implies consequent in the same cycle.
`define FDE_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Antecedent implies consequent in the next cycle.
`define FDE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### rtl/fde_pkg.sv
// Shared types and constants of the finite-difference extrapolator.
// No dependencies; imported by fde_engine and the top level.
`default_nettype none

package fde_pkg;

  localparam int MAX_ORDERS_DEF = 32;
  localparam int SAMPLE_W       = 32;
  localparam int VALUE_W        = 64;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [VALUE_W-1:0]  value_t;

  // Per-sequence sums handed from the engine to the output stage
  typedef struct packed {
    value_t fwd_sum;
    value_t bwd_sum;
    logic   overflow;
  } res_t;

endpackage

`default_nettype wire

### rtl/fde_engine.sv
// Difference-table engine: two single-port-read RAMs (newest and first value
// per order) swept read-modify-write, one order per cycle. Uses fde_pkg.
`default_nettype none
`include "assert_macros.svh"

module fde_engine #(
  parameter int MAX_ORDERS = fde_pkg::MAX_ORDERS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_valid,
  output logic                 s_ready,
  input  wire fde_pkg::sample_t sample,
  input  wire logic            last,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output fde_pkg::res_t        res
);
  import fde_pkg::*;

  localparam int KW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int CW = $clog2(MAX_ORDERS + 1);
  localparam logic [KW-1:0] LAST_K   = KW'(MAX_ORDERS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ORDERS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state;
  logic [KW-1:0] k;
  logic [CW-1:0] count;
  logic          ovf;
  logic          last_q;
  value_t        v;
  value_t        fwd;
  value_t        bwd;

  // Difference RAMs, read data registered
  value_t newest_mem [MAX_ORDERS];
  value_t first_mem  [MAX_ORDERS];
  value_t newest_rd;
  value_t first_rd;

  logic [KW-1:0] rd_addr;
  logic          at_top;
  logic          wr_newest;
  logic          wr_first;
  value_t        term;
  value_t        v_next;
  value_t        fwd_next;
  value_t        bwd_next;

  assign s_ready   = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{fwd_sum: fwd, bwd_sum: bwd, overflow: ovf};

  // Order k is the first unused order when it equals the order count
  assign at_top    = (CW'(k) == count);
  assign wr_newest = (state == S_RUN);
  assign wr_first  = (state == S_RUN) && at_top;

  // Prefetch the next order while the current one is written back
  always_comb begin
    if (state == S_IDLE || k == LAST_K) begin
      rd_addr = '0;
    end else begin
      rd_addr = k + 1'b1;
    end
  end

  // Per-order arithmetic: next difference and both running sums
  assign term     = at_top ? v : first_rd;
  assign v_next   = v - newest_rd;
  assign fwd_next = fwd + v;
  assign bwd_next = k[0] ? (bwd - term) : (bwd + term);

  always_ff @(posedge clk) begin
    newest_rd <= newest_mem[rd_addr];
    first_rd  <= first_mem[rd_addr];
    if (wr_newest) begin
      newest_mem[k] <= v;
    end
    if (wr_first) begin
      first_mem[k] <= v;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_valid) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (at_top) begin
            count <= count + 1'b1;
            state <= last_q ? S_DONE : S_IDLE;
          end else if (k == LAST_K) begin
            ovf   <= 1'b1;
            state <= last_q ? S_DONE : S_IDLE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            count <= '0;
            ovf   <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      v      <= VALUE_W'(sample);
      k      <= '0;
      fwd    <= '0;
      bwd    <= '0;
      last_q <= last;
    end else if (state == S_RUN) begin
      fwd <= fwd_next;
      bwd <= bwd_next;
      v   <= v_next;
      if (!at_top && k != LAST_K) begin
        k <= k + 1'b1;
      end
    end
  end

  `FDE_ASSERT(a_count_range, clk, rst, count <= FULL_CNT)
  `FDE_ASSERT_IMPL(a_ovf_full, clk, rst, ovf, count == FULL_CNT)
  `FDE_ASSERT_IMPL(a_run_index, clk, rst, state == S_RUN, CW'(k) <= count)
  `FDE_ASSERT_NEXT(a_accept_runs, clk, rst, s_valid && s_ready, state == S_RUN)

endmodule

`default_nettype wire

### rtl/finite_difference_extrapolator_unit.sv
// Top level of the finite-difference extrapolator: stream ports, mode
// register, running total and output register. Uses fde_pkg, fde_engine.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tdata: sample; tlast: last_sample
//  m_*      | out | m_tvalid/m_tready  | tdata: extrapolated, running_total;
//           |     |                    | tuser: overflow
//  cfg_*    | in  | cfg_valid/cfg_ready| cfg_data: backward_mode
//
// A sample is accepted in the idle state, then the difference RAMs are swept
// read-modify-write with a registered read, order by order up to the first
// unused order or the last order. A last sample then passes through the done
// state to hand the result to the output register. Reset is synchronous and
// needs no RAM clearing. The output register frees s_tready while a result
// waits; only a second result stalls the engine until m_tready.
`default_nettype none

module finite_difference_extrapolator_unit #(
  parameter int MAX_ORDERS = fde_pkg::MAX_ORDERS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,   // [31:0] sample
  input  wire logic         s_tlast,   // last_sample
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,   // [63:0] extrapolated, [127:64] running_total
  output logic              m_tuser,   // overflow
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_data   // backward_mode
);
  import fde_pkg::*;

  logic   backward_mode;
  logic   res_valid;
  logic   res_ready;
  res_t   res;
  value_t result;
  value_t total;
  value_t total_next;

  fde_engine #(
    .MAX_ORDERS(MAX_ORDERS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_tvalid),
    .s_ready  (s_tready),
    .sample   (sample_t'(s_tdata)),
    .last     (s_tlast),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Mode register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      backward_mode <= 1'b0;
    end else if (cfg_valid) begin
      backward_mode <= cfg_data;
    end
  end

  // Pick the answer and fold it into the running total
  assign result     = backward_mode ? res.bwd_sum : res.fwd_sum;
  assign total_next = total + result;
  assign res_ready  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        total    <= total_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output beat payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {total_next, result};
      m_tuser <= res.overflow;
    end
  end

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for finite_difference_extrapolator_unit.
// Drives sample sequences in both extrapolation modes and checks every result against
// an in-bench difference-table predictor. Depends on rtl/fde_pkg.sv and the unit's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ORDERS        = fde_pkg::MAX_ORDERS_DEF;
  localparam int SETTLE_CYCLES = ORDERS + 8;
  localparam int CYCLE_LIMIT   = 500_000;
  localparam int PHASE_BEATS   = 320;
  localparam int HOLD_AT_BEAT  = 400;
  localparam int HOLD_CYCLES   = 600;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } sample_beat_t;

  typedef struct packed {
    fde_pkg::value_t extrapolated;
    fde_pkg::value_t running_total;
    logic            overflow;
  } extrapolation_t;

  typedef enum logic {MODE_FORWARD = 1'b0, MODE_BACKWARD = 1'b1} mode_t;
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_pattern_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [31:0]   s_tdata = '0;   // [31:0] sample
  logic          s_tlast = 1'b0; // last_sample
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [127:0]  m_tdata;        // [63:0] extrapolated, [127:64] running_total
  logic          m_tuser;        // overflow
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic          cfg_data = 1'b0; // backward_mode

  finite_difference_extrapolator_unit #(.MAX_ORDERS(ORDERS)) dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Shared state between stimulus, driver, monitor and predictor
  sample_beat_t   sample_backlog[$];
  extrapolation_t pending_results[$];
  logic           in_beat_taken = 1'b0;
  logic           hold_off = 1'b0;
  int             mismatches = 0;
  int             samples_in = 0;
  int             sequences_done = 0;
  int             long_sequences = 0;
  int             backward_results = 0;
  int             cycles = 0;

  // Difference-table predictor state
  fde_pkg::value_t diff_newest[ORDERS];
  fde_pkg::value_t diff_first[ORDERS];
  int              orders_used = 0;
  fde_pkg::value_t total_sum = '0;
  logic            seq_too_long = 1'b0;
  mode_t           cur_mode = MODE_FORWARD;

  // Fold one sample into the difference table; on a last sample queue the answer
  task automatic absorb_sample(input logic [31:0] raw, input logic last);
    fde_pkg::value_t v, old, acc;
    extrapolation_t  r;
    logic            placed;
    v = {{32{raw[31]}}, raw};
    placed = 1'b0;
    for (int k = 0; k < ORDERS && !placed; k++) begin
      if (k == orders_used) begin
        diff_newest[k] = v;
        diff_first[k]  = v;
        orders_used++;
        placed = 1'b1;
      end else begin
        old = diff_newest[k];
        diff_newest[k] = v;
        v = v - old;
      end
    end
    // table full: the next order's difference is dropped
    if (!placed) seq_too_long = 1'b1;
    if (last) begin
      acc = '0;
      for (int k = 0; k < orders_used; k++) begin
        if (cur_mode == MODE_FORWARD) acc = acc + diff_newest[k];
        else if (k % 2 == 0) acc = acc + diff_first[k];
        else acc = acc - diff_first[k];
      end
      total_sum = total_sum + acc;
      r.extrapolated  = acc;
      r.running_total = total_sum;
      r.overflow      = seq_too_long;
      pending_results = {pending_results, r};
      if (seq_too_long) long_sequences++;
      if (cur_mode == MODE_BACKWARD) backward_results++;
      orders_used  = 0;
      seq_too_long = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input fde_pkg::value_t got,
                                 input fde_pkg::value_t want);
    $display("MISMATCH @%0t %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Monitor: sample handshakes at the rising edge, predict and check
  always @(posedge clk) begin
    extrapolation_t want;
    cycles <= cycles + 1;
    in_beat_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) cur_mode = mode_t'(cfg_data);
      if (s_tvalid && s_tready) begin
        samples_in++;
        absorb_sample(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", m_tdata[63:0], '0);
        end else begin
          want = pending_results.pop_front();
          sequences_done++;
          if (m_tdata[63:0] !== want.extrapolated)
            report_mismatch("extrapolated", m_tdata[63:0], want.extrapolated);
          if (m_tdata[127:64] !== want.running_total)
            report_mismatch("running_total", m_tdata[127:64], want.running_total);
          if (m_tuser !== want.overflow)
            report_mismatch("overflow", 64'(m_tuser), 64'(want.overflow));
        end
      end
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("finite_difference_extrapolator_unit verification failed");
      $finish;
    end
  end

  // Driver: sender works in bursts separated by random gaps
  int gap_left = 0;
  int burst_left = 20;
  always @(negedge clk) begin
    sample_beat_t beat;
    logic         offer;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_beat_taken) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (sample_backlog.size() > 0) begin
        beat = sample_backlog.pop_front();
        s_tdata <= beat.value;
        s_tlast <= beat.last;
        offer = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 6);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
                                                   : $urandom_range(1, 30);
        end
      end
      s_tvalid <= offer;
    end
  end

  // Receiver: ready pattern that changes every so often, plus the long hold-off
  rx_pattern_t rx_pattern = RX_OPEN;
  int          rx_pattern_left = 0;
  always @(negedge clk) begin
    logic rdy;
    if (rx_pattern_left == 0) begin
      rx_pattern      = rx_pattern_t'($urandom_range(0, 2));
      rx_pattern_left = $urandom_range(20, 200);
    end else begin
      rx_pattern_left--;
    end
    case (rx_pattern)
      RX_OPEN:  rdy = 1'b1;
      RX_LIGHT: rdy = ($urandom_range(0, 3) != 0);
      default:  rdy = ($urandom_range(0, 3) == 0);
    endcase
    m_tready <= rdy && !hold_off;
  end

  // Long receiver hold-off so the result path backs up into the input
  initial begin
    wait (samples_in >= HOLD_AT_BEAT);
    @(posedge clk) hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic push_beat(input logic [31:0] value, input logic last);
    sample_beat_t beat;
    beat.value = value;
    beat.last  = last;
    sample_backlog = {sample_backlog, beat};
  endtask

  // Wait until every beat went in and every result came out, then let the engine settle
  task automatic drain_and_settle();
    do @(posedge clk);
    while (sample_backlog.size() != 0 || s_tvalid || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random sequences: mostly polynomial (differences vanish), some raw noise,
  // some corner values, and now and then one near or beyond the table length
  task automatic queue_random_sequences(input int n_beats);
    int          queued, len, deg, kind;
    logic [31:0] d[5];
    logic [31:0] corner[5];
    logic [31:0] v;
    queued = 0;
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001};
    while (queued < n_beats) begin
      kind = $urandom_range(0, 9);
      len  = (kind == 9) ? $urandom_range(ORDERS - 1, ORDERS + 8) : $urandom_range(1, 12);
      deg  = $urandom_range(0, 4);
      d[0] = ($urandom_range(0, 1) != 0) ? $urandom() : 32'($urandom_range(0, 2000)) - 32'd1000;
      for (int i = 1; i < 5; i++) d[i] = 32'($urandom_range(0, 200)) - 32'd100;
      for (int j = 0; j < len; j++) begin
        if (kind == 6 || kind == 7) begin
          v = $urandom();
        end else if (kind == 8) begin
          v = corner[$urandom_range(0, 4)];
        end else begin
          v = d[0];
          for (int i = 0; i < deg; i++) d[i] = d[i] + d[i + 1];
        end
        push_beat(v, j == len - 1);
      end
      queued += len;
    end
  endtask

  // Stimulus
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    write_mode(MODE_FORWARD);
    // single-sample extremes, then alternating extremes with wrapping differences
    push_beat(32'h7fff_ffff, 1'b1);
    push_beat(32'h8000_0000, 1'b1);
    push_beat(32'h8000_0000, 1'b0);
    push_beat(32'h7fff_ffff, 1'b0);
    push_beat(32'h8000_0000, 1'b0);
    push_beat(32'h7fff_ffff, 1'b1);
    // top order left with one nonzero value
    push_beat(32'd1, 1'b0);
    push_beat(32'd4, 1'b1);
    push_beat(32'd0, 1'b0);
    push_beat(32'd3, 1'b0);
    push_beat(32'd6, 1'b1);
    // mode switch in the middle of a sequence: mode counts at the last sample
    push_beat(32'd1, 1'b0);
    push_beat(32'd4, 1'b0);
    push_beat(32'd9, 1'b0);
    drain_and_settle();
    write_mode(MODE_BACKWARD);
    push_beat(32'd16, 1'b0);
    push_beat(32'd25, 1'b1);
    push_beat(32'd10, 1'b0);
    push_beat(32'd13, 1'b0);
    push_beat(32'd16, 1'b1);
    push_beat(32'hffff_ffff, 1'b1);

    queue_random_sequences(PHASE_BEATS);
    drain_and_settle();
    write_mode(MODE_FORWARD);
    queue_random_sequences(PHASE_BEATS);
    drain_and_settle();
    write_mode(MODE_BACKWARD);
    queue_random_sequences(PHASE_BEATS);
    drain_and_settle();
    write_mode(MODE_FORWARD);
    queue_random_sequences(PHASE_BEATS);
    drain_and_settle();

    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 64'(pending_results.size()), '0);
    $display("Run covered %0d samples in %0d checked sequences over four mode changes.",
             samples_in, sequences_done);
    $display("%0d sequences overran the difference table, %0d extrapolated backward.",
             long_sequences, backward_results);
    if (mismatches == 0) begin
      $display("finite_difference_extrapolator_unit verification clean");
    end else begin
      $display("finite_difference_extrapolator_unit verification failed");
    end
    $finish;
  end

endmodule
